@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands; they expand to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/rbb_pkg.sv @@
// ---------------------------------------------------------------------------
// Reassembly byte buffer package
// Field widths, operation codes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbb_pkg;

    localparam int OP_W        = 2;
    localparam int POS_W       = 16;
    localparam int LEN_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int FOUND_W     = 10;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    // width of the reciprocal used to reduce a position modulo the depth
    localparam int MUL_W       = 32;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_WRITE = 2'd0;
    localparam t_op OP_READ  = 2'd1;
    localparam t_op OP_CHECK = 2'd2;
    localparam t_op OP_FIND  = 2'd3;

    typedef struct packed {
        logic in_ready;
        logic slot_ld;
        logic rd_en;
        logic step;
        logic clr;
        logic vld_we;
        logic vld_wd;
        logic byte_we;
        logic emit;
        logic res_ok;
        logic res_use_byte;
        logic res_found;
        logic res_last;
    } t_rbb_cmd;

    typedef struct packed {
        logic in_fire;
        t_op  op;
        logic left_zero;
        logic left_one;
        logic vld;
        logic out_free;
        logic clr_last;
    } t_rbb_status;

endpackage

`default_nettype wire

@@ hw/rtl/reassembly_byte_buffer_core.sv @@
// ---------------------------------------------------------------------------
// Reassembly byte buffer core
// An accepted beat first loads its start slot; each slot of the run is then read
// from the byte and valid stores and, where the operation needs it, written back.
// A find scans at most DEPTH slots. A result waiting on tready stalls the sequence,
// and an empty check still gives a result beat.
// Reset: synchronous, active low, then a sweep clears the valid bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module reassembly_byte_buffer_core
    import rbb_pkg::*;
#(
    parameter int DEPTH   = 1024,
    parameter int MAX_RUN = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input beats
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata: position [15:0], run_length [22:16], write_byte [30:23], zero [31]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: op [1:0]
    input  wire logic [OP_W-1:0]        i_s_axis_tuser,
    // result beats
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // tdata: read_byte [7:0], ok [8], found_slot [18:9], zero [23:19]
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                        o_m_axis_tlast
);

    t_rbb_cmd    w_cmd;
    t_rbb_status w_st;

    // Controller: clearing sweep after reset, then one operation at a time.
    // It stalls on a full output register, so a result is never overwritten.
    rbb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    // Datapath: slot reduction, stores, run counter and the output register
    // that decouples the result side from the next accepted beat.
    rbb_dp #(
        .DEPTH   (DEPTH),
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

    assign o_s_axis_tready = w_cmd.in_ready;

    // a result is loaded only into a free or draining output register
    `ASSERT_IMPLIES(a_emit_free, i_clk, i_rst_n, w_cmd.emit, w_st.out_free)
    // the clearing sweep owns the valid store and blocks new beats
    `ASSERT_IMPLIES(a_clr_excl, i_clk, i_rst_n, w_cmd.clr, !w_cmd.in_ready && !w_cmd.vld_we)
    // a byte is stored only together with setting its valid bit
    `ASSERT_IMPLIES(a_byte_vld, i_clk, i_rst_n, w_cmd.byte_we, w_cmd.vld_we && w_cmd.vld_wd)
    // an accepted beat makes the block busy on the next cycle
    `ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, w_st.in_fire, !w_cmd.in_ready)

endmodule

`default_nettype wire

@@ hw/rtl/rbb_dp.sv @@
// ---------------------------------------------------------------------------
// Reassembly byte buffer datapath
// Item registers, slot reduction, byte and valid stores, output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbb_dp
    import rbb_pkg::*;
#(
    parameter int DEPTH   = 1024,
    parameter int MAX_RUN = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_rbb_cmd               i_cmd,
    output t_rbb_status                 o_st,
    input  wire logic                   i_s_tvalid,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire t_op                    i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                        o_m_tlast
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = (SLOT_W + 1 > LEN_W) ? SLOT_W + 1 : LEN_W;
    localparam int PROD_W = POS_W + MUL_W;
    localparam int REM_W  = POS_W + 2;
    localparam int PAD_W  = OUT_TDATA_W - BYTE_W - 1 - FOUND_W;

    localparam logic [MUL_W-1:0]  RECIP    = MUL_W'((64'd1 << MUL_W) / DEPTH);
    localparam logic [REM_W-1:0]  DEPTH_R  = REM_W'(DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(DEPTH - 1);
    localparam logic [LEN_W-1:0]  RUN_MAX  = LEN_W'(MAX_RUN);
    localparam logic [CNT_W-1:0]  FIND_CNT = CNT_W'(DEPTH);

    logic [POS_W-1:0]  in_pos;
    logic [LEN_W-1:0]  in_len;
    logic [BYTE_W-1:0] in_wb;
    logic              fire;
    logic [PROD_W-1:0] prod;

    logic [OP_W-1:0]   r_op;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_wbyte;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_q;

    logic [REM_W-1:0]  qd;
    logic [REM_W-1:0]  rem_raw;
    logic [REM_W-1:0]  rem;

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [SLOT_W-1:0] r_clr_cnt;

    logic [BYTE_W-1:0] m_byte [DEPTH];
    logic              m_vld  [DEPTH];
    logic [BYTE_W-1:0] r_byte_q;
    logic              r_vld_q;
    logic [SLOT_W-1:0] vld_wa;
    logic              vld_wd;

    logic                     r_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data;
    logic                     r_out_last;
    logic                     out_free;
    logic [BYTE_W-1:0]        res_byte;
    logic [FOUND_W-1:0]       res_found;
    logic [SLOT_W+FOUND_W-1:0] slot_ext;

    assign in_pos = i_s_tdata[POS_W-1:0];
    assign in_len = i_s_tdata[POS_W+LEN_W-1:POS_W];
    assign in_wb  = i_s_tdata[POS_W+LEN_W+BYTE_W-1:POS_W+LEN_W];
    assign fire   = i_s_tvalid & i_cmd.in_ready;

    // quotient estimate by reciprocal; at most one below the true quotient
    assign prod = PROD_W'(in_pos) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_op    <= i_s_tuser;
            r_len   <= (in_len > RUN_MAX) ? RUN_MAX : in_len;
            r_wbyte <= in_wb;
            r_pos   <= in_pos;
            r_q     <= prod[PROD_W-1:MUL_W];
        end
    end

    // remainder lies below twice the depth: one correction step
    assign qd      = REM_W'(r_q) * DEPTH_R;
    assign rem_raw = REM_W'(r_pos) - qd;
    assign rem     = (rem_raw >= DEPTH_R) ? rem_raw - DEPTH_R : rem_raw;

    always_comb begin
        n_slot = r_slot;
        n_left = r_left;
        if (i_cmd.slot_ld) begin
            n_slot = rem[SLOT_W-1:0];
            n_left = (r_op == OP_FIND) ? FIND_CNT : CNT_W'(r_len);
        end else if (i_cmd.step) begin
            n_slot = (r_slot == SLOT_MAX) ? '0 : r_slot + 1'b1;
            n_left = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_left <= n_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_we) begin
            m_byte[r_slot] <= r_wbyte;
        end
        if (i_cmd.rd_en) begin
            r_byte_q <= m_byte[r_slot];
        end
    end

    // valid store, swept clear after reset
    assign vld_wa = i_cmd.clr ? r_clr_cnt : r_slot;
    assign vld_wd = i_cmd.clr ? 1'b0 : i_cmd.vld_wd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || i_cmd.vld_we) begin
            m_vld[vld_wa] <= vld_wd;
        end
        if (i_cmd.rd_en) begin
            r_vld_q <= m_vld[r_slot];
        end
    end

    assign out_free  = !r_out_valid || i_m_tready;
    assign slot_ext  = (SLOT_W + FOUND_W)'(r_slot);
    assign res_byte  = (i_cmd.res_use_byte && r_vld_q) ? r_byte_q : '0;
    assign res_found = i_cmd.res_found ? slot_ext[FOUND_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {PAD_W'(0), res_found, i_cmd.res_ok, res_byte};
            r_out_last <= i_cmd.res_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    always_comb begin
        o_st.in_fire   = fire;
        o_st.op        = r_op;
        o_st.left_zero = (r_left == '0);
        o_st.left_one  = (r_left == CNT_W'(1));
        o_st.vld       = r_vld_q;
        o_st.out_free  = out_free;
        o_st.clr_last  = (r_clr_cnt == SLOT_MAX);
    end

endmodule

`default_nettype wire

@@ hw/rtl/rbb_ctrl.sv @@
// ---------------------------------------------------------------------------
// Reassembly byte buffer controller
// Sequences the clearing sweep and each operation, one slot at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbb_ctrl
    import rbb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_rbb_status i_st,
    output t_rbb_cmd         o_cmd
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SLOT = 3'd2;
    localparam logic [2:0] ST_RSEL = 3'd3;
    localparam logic [2:0] ST_RDAT = 3'd4;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_st.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_st.in_fire) begin
                    n_state = ST_SLOT;
                end
            end
            ST_SLOT: begin
                o_cmd.slot_ld = 1'b1;
                n_state       = ST_RSEL;
            end
            ST_RSEL: begin
                if (i_st.left_zero && i_st.op == OP_READ) begin
                    n_state = ST_IDLE;
                end else if (i_st.left_zero && i_st.op == OP_CHECK) begin
                    // empty run counts as all valid
                    if (i_st.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.res_ok   = 1'b1;
                        o_cmd.res_last = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_RDAT;
                end
            end
            ST_RDAT: begin
                unique case (i_st.op)
                    OP_WRITE: begin
                        if (i_st.out_free) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.res_ok   = !i_st.vld;
                            o_cmd.res_last = 1'b1;
                            o_cmd.vld_we   = !i_st.vld;
                            o_cmd.vld_wd   = 1'b1;
                            o_cmd.byte_we  = !i_st.vld;
                            n_state        = ST_IDLE;
                        end
                    end
                    OP_READ: begin
                        if (i_st.out_free) begin
                            o_cmd.emit         = 1'b1;
                            o_cmd.res_ok       = i_st.vld;
                            o_cmd.res_use_byte = 1'b1;
                            o_cmd.res_last     = i_st.left_one;
                            o_cmd.vld_we       = 1'b1;
                            o_cmd.step         = 1'b1;
                            n_state = i_st.left_one ? ST_IDLE : ST_RSEL;
                        end
                    end
                    OP_CHECK: begin
                        if (!i_st.vld || i_st.left_one) begin
                            if (i_st.out_free) begin
                                o_cmd.emit     = 1'b1;
                                o_cmd.res_ok   = i_st.vld;
                                o_cmd.res_last = 1'b1;
                                n_state        = ST_IDLE;
                            end
                        end else begin
                            o_cmd.step = 1'b1;
                            n_state    = ST_RSEL;
                        end
                    end
                    OP_FIND: begin
                        if (!i_st.vld || i_st.left_one) begin
                            if (i_st.out_free) begin
                                o_cmd.emit      = 1'b1;
                                o_cmd.res_ok    = !i_st.vld;
                                o_cmd.res_found = !i_st.vld;
                                o_cmd.res_last  = 1'b1;
                                n_state         = ST_IDLE;
                            end
                        end else begin
                            o_cmd.step = 1'b1;
                            n_state    = ST_RSEL;
                        end
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ dv/reassembly_byte_buffer_core_tb.sv @@
// ---------------------------------------------------------------------------
// Reassembly byte buffer core testbench
// Drive write, read, check and find beats through the input stream and
// predict every result beat from a shadow copy of the byte and valid stores.
// A directed table comes first. Random well-formed write/check/find/read
// sequences and noise follow. The sender idles in bursts and the receiver
// stalls on its own pattern.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module reassembly_byte_buffer_core_tb;
    import rbb_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int MAX_RUN      = 64;
    localparam int RANDOM_ITEMS = 150;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TAIL_CYCLES  = 2 * DEPTH + 64;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_byte;
        logic               ok;
        logic [FOUND_W-1:0] found_slot;
        logic               last;
    } t_response;

    // one row of the directed table; pinned rows carry a literal result
    typedef struct packed {
        t_op                op;
        logic [POS_W-1:0]   pos;
        logic [LEN_W-1:0]   len;
        logic [BYTE_W-1:0]  wb;
        logic               pinned;
        logic [BYTE_W-1:0]  p_byte;
        logic               p_ok;
        logic [FOUND_W-1:0] p_slot;
    } t_script_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // tdata: position [15:0], run_length [22:16], write_byte [30:23], zero [31]
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    // tuser: op [1:0]
    logic [OP_W-1:0]        i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // tdata: read_byte [7:0], ok [8], found_slot [18:9], zero [23:19]
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    // shadow of the block's stores
    logic [BYTE_W-1:0] shadow_bytes [DEPTH];
    bit                shadow_valid [DEPTH];

    t_response due_responses[$];

    int unsigned cycle_count   = 0;
    int unsigned fault_count   = 0;
    int unsigned beats_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned burst_left    = 0;

    reassembly_byte_buffer_core #(
        .DEPTH   (DEPTH),
        .MAX_RUN (MAX_RUN)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Work out the result beats of one accepted beat and advance the shadow.
    task automatic buffer_op_response(input t_op op, input logic [POS_W-1:0] pos,
                                      input logic [LEN_W-1:0] len_in,
                                      input logic [BYTE_W-1:0] wb);
        int unsigned slot;
        int unsigned run;
        int unsigned s;
        t_response   r;
        slot = pos % DEPTH;
        run  = (len_in > MAX_RUN) ? MAX_RUN : len_in;
        r    = '0;
        r.last = 1'b1;
        case (op)
            OP_WRITE: begin
                if (!shadow_valid[slot]) begin
                    shadow_bytes[slot] = wb;
                    shadow_valid[slot] = 1'b1;
                    r.ok = 1'b1;
                end
                due_responses.push_back(r);
            end
            OP_READ: begin
                // a zero-length read yields nothing at all
                for (int k = 0; k < run; k++) begin
                    s = (slot + k) % DEPTH;
                    r.ok        = shadow_valid[s];
                    r.read_byte = shadow_valid[s] ? shadow_bytes[s] : '0;
                    r.last      = (k + 1 == run);
                    shadow_valid[s] = 1'b0;
                    due_responses.push_back(r);
                end
            end
            OP_CHECK: begin
                r.ok = 1'b1;
                for (int k = 0; k < run; k++) begin
                    if (!shadow_valid[(slot + k) % DEPTH]) r.ok = 1'b0;
                end
                due_responses.push_back(r);
            end
            OP_FIND: begin
                for (int k = 0; k < DEPTH && !r.ok; k++) begin
                    s = (slot + k) % DEPTH;
                    if (!shadow_valid[s]) begin
                        r.ok         = 1'b1;
                        r.found_slot = s[FOUND_W-1:0];
                    end
                end
                due_responses.push_back(r);
            end
        endcase
    endtask

    // Present one beat, honouring the burst/gap pattern, and hold until taken.
    task automatic send_beat(input t_op op, input logic [POS_W-1:0] pos,
                             input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] wb);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, wb, len, pos};
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        beats_sent++;
        buffer_op_response(op, pos, len, wb);
    endtask

    // Replace the prediction of a single-result beat by a literal value.
    task automatic pin_last_response(input logic [BYTE_W-1:0] rb, input logic ok,
                                     input logic [FOUND_W-1:0] slot);
        t_response r;
        r.read_byte = rb;
        r.ok        = ok;
        r.found_slot = slot;
        r.last      = 1'b1;
        due_responses[due_responses.size() - 1] = r;
    endtask

    task automatic report_fault(input string what, input t_response want,
                                input t_response got);
        fault_count++;
        if (fault_count <= 10) begin
            $write("[%0t] %s: expected byte %02h ok %0d slot %0d last %0d, ",
                   $time, what, want.read_byte, want.ok, want.found_slot, want.last);
            $display("got byte %02h ok %0d slot %0d last %0d",
                     got.read_byte, got.ok, got.found_slot, got.last);
        end
    endtask

    // Receiver: stall on a pattern of its own, switching mode now and then.
    always @(posedge i_clk) begin : result_stall
        static int unsigned mode      = 0;
        static int unsigned mode_left = 0;
        static int unsigned phase     = 0;
        if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
            0:       i_m_axis_tready <= 1'b1;
            1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
            2:       i_m_axis_tready <= (phase % 3 == 0);
            default: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare every result beat with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_response got;
        t_response want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.read_byte  = o_m_axis_tdata[7:0];
            got.ok         = o_m_axis_tdata[8];
            got.found_slot = o_m_axis_tdata[18:9];
            got.last       = o_m_axis_tlast;
            results_seen++;
            if (due_responses.size() == 0) begin
                report_fault("result beat with nothing outstanding", '0, got);
            end else begin
                want = due_responses.pop_front();
                if (got !== want) report_fault("result mismatch", want, got);
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, due_responses.size());
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        t_script_row       script [20];
        logic [POS_W-1:0]  base;
        int unsigned       run;
        int unsigned       random_start;
        int unsigned       directed_beats;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_WRITE;
        i_m_axis_tready = 1'b0;
        for (int s = 0; s < DEPTH; s++) shadow_valid[s] = 1'b0;

        // op, position, run, byte, pinned, byte, ok, slot
        script[0]  = '{OP_FIND,  16'h0000, 7'd0,   8'h00, 1'b1, 8'h00, 1'b1, 10'd0};
        script[1]  = '{OP_FIND,  16'hFFFF, 7'd127, 8'hFF, 1'b1, 8'h00, 1'b1, 10'd1023};
        script[2]  = '{OP_CHECK, 16'h0000, 7'd0,   8'h00, 1'b1, 8'h00, 1'b1, 10'd0};
        script[3]  = '{OP_CHECK, 16'h0005, 7'd1,   8'h00, 1'b1, 8'h00, 1'b0, 10'd0};
        script[4]  = '{OP_READ,  16'h0007, 7'd0,   8'h00, 1'b0, 8'h00, 1'b0, 10'd0};
        script[5]  = '{OP_READ,  16'h0003, 7'd1,   8'h00, 1'b1, 8'h00, 1'b0, 10'd0};
        script[6]  = '{OP_WRITE, 16'h0000, 7'd0,   8'hFF, 1'b1, 8'h00, 1'b1, 10'd0};
        // same slot one lap later: dropped
        script[7]  = '{OP_WRITE, 16'h0400, 7'd0,   8'h00, 1'b1, 8'h00, 1'b0, 10'd0};
        script[8]  = '{OP_WRITE, 16'hFFFF, 7'd127, 8'hA5, 1'b1, 8'h00, 1'b1, 10'd0};
        script[9]  = '{OP_WRITE, 16'h0001, 7'd0,   8'h5A, 1'b1, 8'h00, 1'b1, 10'd0};
        script[10] = '{OP_FIND,  16'h03FF, 7'd0,   8'h00, 1'b1, 8'h00, 1'b1, 10'd2};
        script[11] = '{OP_CHECK, 16'hFBFF, 7'd3,   8'h00, 1'b1, 8'h00, 1'b1, 10'd0};
        script[12] = '{OP_CHECK, 16'h03FF, 7'd4,   8'h00, 1'b1, 8'h00, 1'b0, 10'd0};
        // read across the wrap, then an over-long run that saturates
        script[13] = '{OP_READ,  16'h03FF, 7'd3,   8'h00, 1'b0, 8'h00, 1'b0, 10'd0};
        script[14] = '{OP_CHECK, 16'h0000, 7'd127, 8'h00, 1'b1, 8'h00, 1'b0, 10'd0};
        script[15] = '{OP_READ,  16'h0000, 7'd127, 8'h00, 1'b0, 8'h00, 1'b0, 10'd0};
        script[16] = '{OP_WRITE, 16'h01F4, 7'd0,   8'h11, 1'b1, 8'h00, 1'b1, 10'd0};
        script[17] = '{OP_WRITE, 16'h01F5, 7'd0,   8'h22, 1'b1, 8'h00, 1'b1, 10'd0};
        script[18] = '{OP_READ,  16'h01F3, 7'd64,  8'h00, 1'b0, 8'h00, 1'b0, 10'd0};
        script[19] = '{OP_READ,  16'h0000, 7'd1,   8'h00, 1'b1, 8'h00, 1'b0, 10'd0};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int n = 0; n < 20; n++) begin
            send_beat(script[n].op, script[n].pos, script[n].len, script[n].wb);
            if (script[n].pinned) begin
                pin_last_response(script[n].p_byte, script[n].p_ok, script[n].p_slot);
            end
        end
        directed_beats = beats_sent;

        // random: mostly write/check/find/read sequences on one run, some noise
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                base = POS_W'($urandom);
                run  = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64)
                                                   : $urandom_range(1, 12);
                for (int k = 0; k < run; k++) begin
                    // leave the odd hole so check and find see gaps
                    if ($urandom_range(0, 9) != 0) begin
                        send_beat(OP_WRITE, POS_W'(base + k), LEN_W'($urandom),
                                  BYTE_W'($urandom));
                    end
                end
                if ($urandom_range(0, 4) == 0) begin
                    send_beat(OP_WRITE, POS_W'(base + $urandom_range(0, run - 1)),
                              LEN_W'($urandom), BYTE_W'($urandom));
                end
                send_beat(OP_CHECK, base, LEN_W'(run), BYTE_W'($urandom));
                send_beat(OP_FIND, base, LEN_W'($urandom), BYTE_W'($urandom));
                send_beat(OP_READ, base,
                          ($urandom_range(0, 5) == 0) ? LEN_W'($urandom_range(0, 127))
                                                      : LEN_W'(run),
                          BYTE_W'($urandom));
            end else begin
                send_beat(t_op'($urandom_range(0, 3)), POS_W'($urandom),
                          LEN_W'($urandom_range(0, 127)), BYTE_W'($urandom));
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // hold until drained, then leave room for any stray result beat
        while (due_responses.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats (%0d directed, the rest random runs and noise)",
                 beats_sent, directed_beats);
        $display("Checked %0d result beats over %0d cycles, %0d faults",
                 results_seen, cycle_count, fault_count);
        if (fault_count == 0 && due_responses.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
